### rtl/ssa_pkg.sv
`default_nettype none

package ssa_pkg;

    localparam logic [15:0] HOLD_TIMEOUT_RESET = 16'd200;

    localparam int HELD_POS_DIST  = 0;
    localparam int HELD_NEG_DIST  = 1;
    localparam int HELD_POS_DUR   = 2;
    localparam int HELD_NEG_DUR   = 3;
    localparam int HELD_MOVES     = 4;
    localparam int HELD_STILLS    = 5;
    localparam int HELD_COUNT     = 6;

    typedef struct packed {
        logic signed [15:0] position;
        logic        [31:0] timestamp;
        logic        [31:0] ms_time;
        logic               report_tick;
    } t_sample;

    typedef struct packed {
        logic               report_valid;
        logic        [15:0] pos_distance;
        logic        [15:0] neg_distance;
        logic        [15:0] pos_duration;
        logic        [15:0] neg_duration;
        logic signed [15:0] move_samples;
        logic signed [15:0] still_samples;
    } t_report;

endpackage

`default_nettype wire

### rtl/steering_speed_accumulator.sv
// Steering speed accumulator.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one wheel
// sample per transfer: signed position, 2 us timer, millisecond clock and a
// report tick. Output channel (o_out_valid / i_out_ready / o_out_data) returns
// exactly one report per sample: report_valid mirrors the tick, the other
// fields are the latched motion sums and counts.
// A sample sits in the input register until it advances, then its update is
// applied to the accumulators and its report is written to the output
// register.
// One sample per cycle is sustained while the receiver does not stall; the
// single add/compare pass between the input register and the output register
// sets that figure.
// hold_timeout_ms is to be written through i_cfg_we / i_cfg_data only while
// idle; the block itself does not enforce this. Reset clears all
// accumulators, timers and latched values, sets the hold timeout to 200 ms
// and empties both registers. When the receiver stalls, the report holds in
// the output register, the next sample waits in the input register, and
// o_in_ready drops only once both are full.
`default_nettype none

module steering_speed_accumulator (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire ssa_pkg::t_sample i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output ssa_pkg::t_report      o_out_data,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_data
);
    import ssa_pkg::*;

    logic        r_in_valid;
    t_sample     r_in;
    logic        r_out_valid;
    t_report     r_out;
    logic [15:0] r_hold_timeout;

    logic [15:0] r_prev_position;
    logic [31:0] r_last_pos_time;
    logic [31:0] r_last_neg_time;
    logic [15:0] r_acc_pos_dist;
    logic [15:0] r_acc_neg_dist;
    logic [15:0] r_acc_pos_dur;
    logic [15:0] r_acc_neg_dur;
    logic [31:0] r_acc_moves;
    logic [15:0] r_acc_stills;
    logic [31:0] r_last_report_ms;
    logic [HELD_COUNT-1:0][15:0] r_held;

    logic [15:0] n_prev_position;
    logic [31:0] n_last_pos_time;
    logic [31:0] n_last_neg_time;
    logic [15:0] n_acc_pos_dist;
    logic [15:0] n_acc_neg_dist;
    logic [15:0] n_acc_pos_dur;
    logic [15:0] n_acc_neg_dur;
    logic [31:0] n_acc_moves;
    logic [15:0] n_acc_stills;
    logic [31:0] n_last_report_ms;
    logic [HELD_COUNT-1:0][15:0] n_held;
    t_report     n_out;

    logic        advance;
    logic        take;
    logic signed [16:0] delta;
    logic [15:0] neg_mag;
    logic [31:0] ms_elapsed;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign take       = (r_in.timestamp > r_last_pos_time) ||
                        (r_in.timestamp > r_last_neg_time);
    assign delta      = 17'(r_in.position) - 17'($signed(r_prev_position));
    assign neg_mag    = 16'(-delta);
    assign ms_elapsed = r_in.ms_time - r_last_report_ms;

    always_comb begin
        n_prev_position  = r_prev_position;
        n_last_pos_time  = r_last_pos_time;
        n_last_neg_time  = r_last_neg_time;
        n_acc_pos_dist   = r_acc_pos_dist;
        n_acc_neg_dist   = r_acc_neg_dist;
        n_acc_pos_dur    = r_acc_pos_dur;
        n_acc_neg_dur    = r_acc_neg_dur;
        n_acc_moves      = r_acc_moves;
        n_acc_stills     = r_acc_stills;
        n_last_report_ms = r_last_report_ms;
        n_held           = r_held;

        // fold this sample into the running sums
        if (take) begin
            if (delta < 0) begin
                n_acc_neg_dist  = r_acc_neg_dist + neg_mag;
                n_acc_neg_dur   = r_acc_neg_dur +
                                  16'(r_in.timestamp - r_last_neg_time);
                n_acc_moves     = r_acc_moves + 32'd1;
                n_last_neg_time = r_in.timestamp;
            end else if (delta > 0) begin
                n_acc_pos_dist  = r_acc_pos_dist + 16'(delta);
                n_acc_pos_dur   = r_acc_pos_dur +
                                  16'(r_in.timestamp - r_last_pos_time);
                n_acc_moves     = r_acc_moves + 32'd1;
                n_last_pos_time = r_in.timestamp;
            end else begin
                n_acc_stills    = r_acc_stills + 16'd1;
            end
            n_prev_position = r_in.position;
        end

        // close the reporting cycle
        if (r_in.report_tick) begin
            if (n_acc_moves != 32'd0) begin
                n_held[HELD_POS_DIST] = n_acc_pos_dist;
                n_held[HELD_NEG_DIST] = n_acc_neg_dist;
                n_held[HELD_POS_DUR]  = n_acc_pos_dur;
                n_held[HELD_NEG_DUR]  = n_acc_neg_dur;
                n_held[HELD_MOVES]    = n_acc_moves[15:0];
                n_held[HELD_STILLS]   = n_acc_stills;
                n_last_report_ms      = r_in.ms_time;
            end else if (ms_elapsed >= {16'd0, r_hold_timeout}) begin
                n_held           = '0;
                n_last_report_ms = r_in.ms_time;
                n_last_pos_time  = r_in.timestamp;
                n_last_neg_time  = r_in.timestamp;
            end else if ($signed(r_held[HELD_MOVES]) > 16'sd0) begin
                n_held[HELD_MOVES] = 16'(-r_held[HELD_MOVES]);
            end
            n_acc_pos_dist = '0;
            n_acc_neg_dist = '0;
            n_acc_pos_dur  = '0;
            n_acc_neg_dur  = '0;
            n_acc_moves    = '0;
            n_acc_stills   = '0;
        end

        n_out.report_valid  = r_in.report_tick;
        n_out.pos_distance  = n_held[HELD_POS_DIST];
        n_out.neg_distance  = n_held[HELD_NEG_DIST];
        n_out.pos_duration  = n_held[HELD_POS_DUR];
        n_out.neg_duration  = n_held[HELD_NEG_DUR];
        n_out.move_samples  = n_held[HELD_MOVES];
        n_out.still_samples = n_held[HELD_STILLS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_hold_timeout   <= HOLD_TIMEOUT_RESET;
            r_prev_position  <= '0;
            r_last_pos_time  <= '0;
            r_last_neg_time  <= '0;
            r_acc_pos_dist   <= '0;
            r_acc_neg_dist   <= '0;
            r_acc_pos_dur    <= '0;
            r_acc_neg_dur    <= '0;
            r_acc_moves      <= '0;
            r_acc_stills     <= '0;
            r_last_report_ms <= '0;
            r_held           <= '0;
        end else begin
            if (i_cfg_we) begin
                r_hold_timeout <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_prev_position  <= n_prev_position;
                r_last_pos_time  <= n_last_pos_time;
                r_last_neg_time  <= n_last_neg_time;
                r_acc_pos_dist   <= n_acc_pos_dist;
                r_acc_neg_dist   <= n_acc_neg_dist;
                r_acc_pos_dur    <= n_acc_pos_dur;
                r_acc_neg_dur    <= n_acc_neg_dur;
                r_acc_moves      <= n_acc_moves;
                r_acc_stills     <= n_acc_stills;
                r_last_report_ms <= n_last_report_ms;
                r_held           <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_stall_only_on_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && o_out_valid && !i_out_ready))
        else $error("input stalled while output side free");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_held_stable_without_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in.report_tick) |=> $stable(r_held))
        else $error("latched values changed without a tick");

    a_clear_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.report_tick) |=> (r_acc_moves == 32'd0 && r_acc_stills == 16'd0))
        else $error("accumulators not cleared after tick");

endmodule

`default_nettype wire
